// ===== hdl/clp_pkg.sv =====
`timescale 1ns / 1ps

package clp_pkg;

	// Request kinds on the input channel
	typedef enum logic {
		REQ_START = 1'b0,
		REQ_STEP  = 1'b1
	} req_t;

	// Clip window register indexes
	typedef enum logic [1:0] {
		CFG_CLIP_LEFT   = 2'd0,
		CFG_CLIP_TOP    = 2'd1,
		CFG_CLIP_WIDTH  = 2'd2,
		CFG_CLIP_HEIGHT = 2'd3
	} cfg_idx_t;

	// Step direction of one axis
	typedef enum logic [1:0] {
		DIR_NONE = 2'b00,
		DIR_POS  = 2'b01,
		DIR_NEG  = 2'b11
	} dir_t;

	typedef struct packed {
		dir_t col;
		dir_t row;
	} dirs_t;

endpackage

// ===== hdl/clp_req_if.sv =====
`timescale 1ns / 1ps

interface clp_req_if #(
	parameter int COORD_WIDTH = 12,
	parameter int COLOR_WIDTH = 24
);
	logic                   valid;
	logic                   ready;
	clp_pkg::req_t          req_type;
	logic [COORD_WIDTH-1:0] start_x;
	logic [COORD_WIDTH-1:0] start_y;
	logic [COORD_WIDTH-1:0] end_x;
	logic [COORD_WIDTH-1:0] end_y;
	logic [COLOR_WIDTH-1:0] line_color;

	modport source (
		output valid, req_type, start_x, start_y, end_x, end_y, line_color,
		input  ready
	);
	modport sink (
		input  valid, req_type, start_x, start_y, end_x, end_y, line_color,
		output ready
	);
endinterface

// ===== hdl/clp_pix_if.sv =====
`timescale 1ns / 1ps

interface clp_pix_if #(
	parameter int COORD_WIDTH = 12,
	parameter int COLOR_WIDTH = 24
);
	logic                   valid;
	logic                   ready;
	logic [COORD_WIDTH-1:0] pixel_x;
	logic [COORD_WIDTH-1:0] pixel_y;
	logic [COLOR_WIDTH-1:0] pixel_color;
	logic                   visible;
	logic                   last_pixel;

	modport source (
		output valid, pixel_x, pixel_y, pixel_color, visible, last_pixel,
		input  ready
	);
	modport sink (
		input  valid, pixel_x, pixel_y, pixel_color, visible, last_pixel,
		output ready
	);
endinterface

// ===== hdl/clp_line_setup.sv =====
`timescale 1ns / 1ps

// Endpoint decode: per-axis direction and magnitude, major distance.
module clp_line_setup #(
	parameter int COORD_WIDTH = 12
) (
	input  logic [COORD_WIDTH-1:0] start_x,
	input  logic [COORD_WIDTH-1:0] start_y,
	input  logic [COORD_WIDTH-1:0] end_x,
	input  logic [COORD_WIDTH-1:0] end_y,
	output clp_pkg::dirs_t         dirs,
	output logic [COORD_WIDTH-1:0] abs_dx,
	output logic [COORD_WIDTH-1:0] abs_dy,
	output logic [COORD_WIDTH-1:0] major_len
);
	logic [COORD_WIDTH:0] dx;
	logic [COORD_WIDTH:0] dy;
	logic [COORD_WIDTH:0] ndx;
	logic [COORD_WIDTH:0] ndy;

	assign dx  = {end_x[COORD_WIDTH-1], end_x} - {start_x[COORD_WIDTH-1], start_x};
	assign dy  = {end_y[COORD_WIDTH-1], end_y} - {start_y[COORD_WIDTH-1], start_y};
	assign ndx = -dx;
	assign ndy = -dy;

	always_comb begin
		abs_dx = dx[COORD_WIDTH] ? ndx[COORD_WIDTH-1:0] : dx[COORD_WIDTH-1:0];
		abs_dy = dy[COORD_WIDTH] ? ndy[COORD_WIDTH-1:0] : dy[COORD_WIDTH-1:0];
		major_len = (abs_dx > abs_dy) ? abs_dx : abs_dy;

		if (dx == '0)
			dirs.col = clp_pkg::DIR_NONE;
		else if (dx[COORD_WIDTH])
			dirs.col = clp_pkg::DIR_NEG;
		else
			dirs.col = clp_pkg::DIR_POS;

		if (dy == '0)
			dirs.row = clp_pkg::DIR_NONE;
		else if (dy[COORD_WIDTH])
			dirs.row = clp_pkg::DIR_NEG;
		else
			dirs.row = clp_pkg::DIR_POS;
	end
endmodule

// ===== hdl/clp_axis_step.sv =====
`timescale 1ns / 1ps

// One axis of the error-accumulator step.
module clp_axis_step #(
	parameter int COORD_WIDTH = 12
) (
	input  logic [COORD_WIDTH-1:0] pos,
	input  clp_pkg::dir_t          dir,
	input  logic [COORD_WIDTH:0]   err,
	input  logic [COORD_WIDTH-1:0] delta,
	input  logic [COORD_WIDTH-1:0] major_len,
	output logic [COORD_WIDTH-1:0] pos_next,
	output logic [COORD_WIDTH:0]   err_next
);
	logic [COORD_WIDTH:0] err_sum;
	logic                 move;

	// err never exceeds major_len after a step, so the sum fits one extra bit
	assign err_sum = err + {1'b0, delta};
	assign move    = err_sum > {1'b0, major_len};

	always_comb begin
		err_next = move ? (err_sum - {1'b0, major_len}) : err_sum;
		pos_next = pos;
		if (move) begin
			case (dir)
				clp_pkg::DIR_POS: pos_next = pos + 1'b1;
				clp_pkg::DIR_NEG: pos_next = pos - 1'b1;
				default:          pos_next = pos;
			endcase
		end
	end
endmodule

// ===== hdl/clp_clip_test.sv =====
`timescale 1ns / 1ps

// Clip window test: left/top inclusive, right/bottom exclusive.
module clp_clip_test #(
	parameter int COORD_WIDTH = 12
) (
	input  logic [COORD_WIDTH-1:0] x,
	input  logic [COORD_WIDTH-1:0] y,
	input  logic [COORD_WIDTH-1:0] left,
	input  logic [COORD_WIDTH-1:0] top,
	input  logic [COORD_WIDTH-1:0] width,
	input  logic [COORD_WIDTH-1:0] height,
	output logic                   visible
);
	logic signed [COORD_WIDTH+1:0] xe, ye, le, te, re, be;

	assign xe = $signed({{2{x[COORD_WIDTH-1]}}, x});
	assign ye = $signed({{2{y[COORD_WIDTH-1]}}, y});
	assign le = $signed({{2{left[COORD_WIDTH-1]}}, left});
	assign te = $signed({{2{top[COORD_WIDTH-1]}}, top});
	assign re = le + $signed({2'b00, width});
	assign be = te + $signed({2'b00, height});

	assign visible = (xe >= le) && (ye >= te) && (xe < re) && (ye < be);
endmodule

// ===== hdl/clipped_line_pixel_generator.sv =====
`timescale 1ns / 1ps
// A step transaction's pixel is registered: it shows on the output in the cycle after
// acceptance. Throughput: one transaction per clock while req.ready is high; the output
// register frees itself in the same cycle it is taken, so a step can be accepted while
// the last pixel is read. Start transactions give no pixel. Reset (arst_n low) clears
// the line-active flag and the output valid and loads the clip window with 0, 0,
// SCREEN_W, SCREEN_H; line data waits for a start, pixel data for a step.
module clipped_line_pixel_generator #(
	parameter int COORD_WIDTH = 12,
	parameter int COLOR_WIDTH = 24,
	parameter int SCREEN_W    = 320,
	parameter int SCREEN_H    = 240
) (
	input  logic                   clk,
	input  logic                   arst_n,
	clp_req_if.sink                req,
	clp_pix_if.source              pix,
	input  logic                   cfg_we,
	input  clp_pkg::cfg_idx_t      cfg_index,
	input  logic [COORD_WIDTH-1:0] cfg_data
);
	// Clip window registers
	logic [COORD_WIDTH-1:0] clip_left_q, clip_top_q, clip_width_q, clip_height_q;

	// Line state
	logic                   busy_q;
	logic [COORD_WIDTH-1:0] col_q, row_q;
	logic [COORD_WIDTH:0]   err_col_q, err_row_q;
	logic [COORD_WIDTH-1:0] abs_dx_q, abs_dy_q, major_q;
	clp_pkg::dirs_t         dirs_q;
	logic [COORD_WIDTH:0]   left_q;    // pixels still to emit, major+2 at start
	logic [COLOR_WIDTH-1:0] color_q;

	// Output register
	logic                   out_vld_q;
	logic [COORD_WIDTH-1:0] out_x_q, out_y_q;
	logic [COLOR_WIDTH-1:0] out_color_q;
	logic                   out_vis_q, out_last_q;

	// Setup results for a start transaction
	clp_pkg::dirs_t         su_dirs;
	logic [COORD_WIDTH-1:0] su_adx, su_ady, su_major;

	// Step results
	logic [COORD_WIDTH-1:0] col_nx, row_nx;
	logic [COORD_WIDTH:0]   err_col_nx, err_row_nx;
	logic                   vis;

	logic accept, do_start, do_step, is_last;

	// The output register is free when empty or being drained this cycle
	assign req.ready = !out_vld_q || pix.ready;
	assign accept    = req.valid && req.ready;
	assign do_start  = accept && (req.req_type == clp_pkg::REQ_START);
	// A step with no active line is swallowed without a pixel
	assign do_step   = accept && (req.req_type == clp_pkg::REQ_STEP) && busy_q;
	assign is_last   = (left_q == (COORD_WIDTH+1)'(1));

	clp_line_setup #(.COORD_WIDTH(COORD_WIDTH)) u_setup (
		.start_x   (req.start_x),
		.start_y   (req.start_y),
		.end_x     (req.end_x),
		.end_y     (req.end_y),
		.dirs      (su_dirs),
		.abs_dx    (su_adx),
		.abs_dy    (su_ady),
		.major_len (su_major)
	);

	clp_axis_step #(.COORD_WIDTH(COORD_WIDTH)) u_step_col (
		.pos       (col_q),
		.dir       (dirs_q.col),
		.err       (err_col_q),
		.delta     (abs_dx_q),
		.major_len (major_q),
		.pos_next  (col_nx),
		.err_next  (err_col_nx)
	);

	clp_axis_step #(.COORD_WIDTH(COORD_WIDTH)) u_step_row (
		.pos       (row_q),
		.dir       (dirs_q.row),
		.err       (err_row_q),
		.delta     (abs_dy_q),
		.major_len (major_q),
		.pos_next  (row_nx),
		.err_next  (err_row_nx)
	);

	// Visibility is judged on the pixel being emitted, i.e. the current position
	clp_clip_test #(.COORD_WIDTH(COORD_WIDTH)) u_clip (
		.x       (col_q),
		.y       (row_q),
		.left    (clip_left_q),
		.top     (clip_top_q),
		.width   (clip_width_q),
		.height  (clip_height_q),
		.visible (vis)
	);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_left_q   <= '0;
			clip_top_q    <= '0;
			clip_width_q  <= COORD_WIDTH'(SCREEN_W);
			clip_height_q <= COORD_WIDTH'(SCREEN_H);
		end else if (cfg_we) begin
			unique case (cfg_index)
				clp_pkg::CFG_CLIP_LEFT:   clip_left_q   <= cfg_data;
				clp_pkg::CFG_CLIP_TOP:    clip_top_q    <= cfg_data;
				clp_pkg::CFG_CLIP_WIDTH:  clip_width_q  <= cfg_data;
				clp_pkg::CFG_CLIP_HEIGHT: clip_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Control state: line active flag and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (do_start)
				busy_q <= 1'b1;
			else if (do_step && is_last)
				busy_q <= 1'b0;

			if (do_step)
				out_vld_q <= 1'b1;
			else if (pix.ready)
				out_vld_q <= 1'b0;
		end
	end

	// Line payload: loaded on start, advanced on each emitted pixel.
	// A start while a line is running simply reloads everything.
	always_ff @(posedge clk) begin
		if (do_start) begin
			col_q     <= req.start_x;
			row_q     <= req.start_y;
			err_col_q <= '0;
			err_row_q <= '0;
			abs_dx_q  <= su_adx;
			abs_dy_q  <= su_ady;
			major_q   <= su_major;
			dirs_q    <= su_dirs;
			left_q    <= {1'b0, su_major} + (COORD_WIDTH+1)'(2);
			color_q   <= req.line_color;
		end else if (do_step) begin
			col_q     <= col_nx;
			row_q     <= row_nx;
			err_col_q <= err_col_nx;
			err_row_q <= err_row_nx;
			left_q    <= left_q - (COORD_WIDTH+1)'(1);
		end
	end

	// Pixel output register
	always_ff @(posedge clk) begin
		if (do_step) begin
			out_x_q     <= col_q;
			out_y_q     <= row_q;
			out_color_q <= color_q;
			out_vis_q   <= vis;
			out_last_q  <= is_last;
		end
	end

	assign pix.valid       = out_vld_q;
	assign pix.pixel_x     = out_x_q;
	assign pix.pixel_y     = out_y_q;
	assign pix.pixel_color = out_color_q;
	assign pix.visible     = out_vis_q;
	assign pix.last_pixel  = out_last_q;
endmodule
